// ===== hw/rtl/segment_box_clip_test_macros.svh =====
// Assertion macros used by the checker file of segment_box_clip_test.
// No dependencies.
`ifndef SEGMENT_BOX_CLIP_TEST_MACROS_SVH
`define SEGMENT_BOX_CLIP_TEST_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define SBCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge outside reset.
`define SBCT_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== hw/rtl/sbct_pkg.sv =====
// Package for segment_box_clip_test: default widths, side codes, divider bits per stage.
// No dependencies.
package sbct_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned T_FRAC_BITS_DEF = 16;

  // Quotient bits resolved by each divider stage.
  localparam int unsigned DIV_BITS_PER_STAGE = 4;

  localparam logic [2:0] NORMAL_NONE   = 3'd0;
  localparam logic [2:0] NORMAL_LEFT   = 3'd1;
  localparam logic [2:0] NORMAL_RIGHT  = 3'd2;
  localparam logic [2:0] NORMAL_TOP    = 3'd3;
  localparam logic [2:0] NORMAL_BOTTOM = 3'd4;

  localparam logic [2:0] SIDE_CODE [4] = '{NORMAL_LEFT, NORMAL_RIGHT, NORMAL_TOP, NORMAL_BOTTOM};

endpackage

// ===== hw/rtl/segment_box_clip_test.sv =====
// Liang-Barsky segment against box test, fully pipelined.
// Depends on sbct_pkg.
//
//  channel   | direction | tdata fields (lowest bit first)
//  s_axis    | in        | box_left, box_top, box_right, box_bottom, start_x, start_y, end_x, end_y
//  m_axis    | out       | hit, t_enter, t_exit, normal_code
//
// One request enters per cycle while m_axis is not stalled. The four restoring dividers
// resolve four quotient bits per stage.
// Reset clears only the valid bits of every stage.
// All stages advance together; a stall on m_axis freezes the pipe and holds s_axis_tready low.
module segment_box_clip_test #(
  parameter int unsigned COORD_WIDTH = sbct_pkg::COORD_WIDTH_DEF,
  parameter int unsigned T_FRAC_BITS = sbct_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // box_left, box_top, box_right, box_bottom, start_x, start_y, end_x, end_y
  input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // hit, t_enter, t_exit, normal_code, zero pad
  output logic [((2*T_FRAC_BITS+6+7)/8)*8-1:0]     m_axis_tdata
);
  import sbct_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned F      = T_FRAC_BITS;
  localparam int unsigned DW     = CW + 1;
  localparam int unsigned NW     = DW + F;
  localparam int unsigned TW     = NW + 1;
  localparam int unsigned RW     = DW + 1;
  localparam int unsigned K      = DIV_BITS_PER_STAGE;
  localparam int unsigned NST    = (NW + K - 1) / K;
  localparam int unsigned PW     = NST * K;
  localparam int unsigned OUT_W  = ((2*F+6+7)/8)*8;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << F;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [PW-1:0] num;
    logic [PW-1:0] quo;
    logic [DW-1:0] den;
    logic          neg;
    logic          pneg;
    logic          pz;
    logic          qneg;
  } div_t;

  typedef struct packed {
    logic          pneg;
    logic          pz;
    logic          qneg;
  } side_t;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- prep stage: side pairs (p, q) and magnitudes
  logic signed [CW-1:0] fld [8];
  logic signed [DW-1:0] p_w [4];
  logic signed [DW-1:0] q_w [4];
  logic signed [DW-1:0] dx, dy;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fld[i] = s_axis_tdata[i*CW +: CW];
    end
    dx = DW'(fld[6]) - DW'(fld[4]);
    dy = DW'(fld[7]) - DW'(fld[5]);
    p_w[0] = -dx;
    q_w[0] = DW'(fld[4]) - DW'(fld[0]);
    p_w[1] = dx;
    q_w[1] = DW'(fld[2]) - DW'(fld[4]);
    p_w[2] = -dy;
    q_w[2] = DW'(fld[5]) - DW'(fld[1]);
    p_w[3] = dy;
    q_w[3] = DW'(fld[3]) - DW'(fld[5]);
  end

  logic          v0_q;
  logic [DW-1:0] pm_q [4];
  logic [DW-1:0] qm_q [4];
  side_t         sd0_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pm_q[j]       <= p_w[j][DW-1] ? DW'(-p_w[j]) : DW'(p_w[j]);
        qm_q[j]       <= q_w[j][DW-1] ? DW'(-q_w[j]) : DW'(q_w[j]);
        sd0_q[j].pneg <= p_w[j][DW-1];
        sd0_q[j].pz   <= (p_w[j] == '0);
        sd0_q[j].qneg <= q_w[j][DW-1];
      end
    end
  end

  // ---------------- restoring dividers, K quotient bits per stage
  div_t div_st [NST+1][4];
  logic dv     [NST+1];

  assign dv[0] = v0_q;
  for (genvar j = 0; j < 4; j++) begin : g_div_in
    assign div_st[0][j] = '{rem:  '0,
                            num:  PW'({qm_q[j], {F{1'b0}}}),
                            quo:  '0,
                            den:  pm_q[j],
                            neg:  sd0_q[j].pneg ^ sd0_q[j].qneg,
                            pneg: sd0_q[j].pneg,
                            pz:   sd0_q[j].pz,
                            qneg: sd0_q[j].qneg};
  end

  for (genvar s = 0; s < NST; s++) begin : g_div
    div_t st_d [4];
    div_t st_q [4];
    logic v_q;

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        st_d[j] = div_st[s][j];
        for (int k = 0; k < K; k++) begin
          st_d[j].rem = {st_d[j].rem[RW-2:0], st_d[j].num[PW-1]};
          st_d[j].num = {st_d[j].num[PW-2:0], 1'b0};
          if (st_d[j].rem >= {1'b0, st_d[j].den}) begin
            st_d[j].rem = st_d[j].rem - {1'b0, st_d[j].den};
            st_d[j].quo = {st_d[j].quo[PW-2:0], 1'b1};
          end else begin
            st_d[j].quo = {st_d[j].quo[PW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= dv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q <= st_d;
      end
    end

    assign dv[s+1] = v_q;
    for (genvar j = 0; j < 4; j++) begin : g_out
      assign div_st[s+1][j] = st_q[j];
    end
  end

  // ---------------- signed parameters
  logic                 vt_q;
  logic signed [TW-1:0] t_q [4];
  side_t                sdt_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (en) begin
      vt_q <= dv[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        t_q[j] <= div_st[NST][j].neg ? -$signed(TW'(div_st[NST][j].quo[NW-1:0]))
                                     :  $signed(TW'(div_st[NST][j].quo[NW-1:0]));
        sdt_q[j] <= '{pneg: div_st[NST][j].pneg, pz: div_st[NST][j].pz,
                      qneg: div_st[NST][j].qneg};
      end
    end
  end

  // ---------------- clip sides: left and right, then top and bottom
  logic                 va_q, vb_q;
  logic signed [TW-1:0] tin_a_q, tout_a_q, tin_b_q, tout_b_q;
  logic [2:0]           code_a_q, code_b_q;
  logic                 rej_a_q, rej_b_q;
  logic signed [TW-1:0] t_a_q [2];
  side_t                sd_a_q [2];

  logic signed [TW-1:0] tin_a_d, tout_a_d, tin_b_d, tout_b_d;
  logic [2:0]           code_a_d, code_b_d;
  logic                 rej_a_d, rej_b_d;

  always_comb begin
    tin_a_d  = '0;
    tout_a_d = T_ONE;
    code_a_d = NORMAL_NONE;
    rej_a_d  = 1'b0;
    for (int j = 0; j < 2; j++) begin
      if (!rej_a_d) begin
        if (sdt_q[j].pz) begin
          rej_a_d = sdt_q[j].qneg;
        end else if (sdt_q[j].pneg) begin
          if (t_q[j] > tin_a_d) begin
            tin_a_d  = t_q[j];
            code_a_d = SIDE_CODE[j];
          end
        end else if (t_q[j] < tout_a_d) begin
          tout_a_d = t_q[j];
        end
      end
    end
  end

  always_comb begin
    tin_b_d  = tin_a_q;
    tout_b_d = tout_a_q;
    code_b_d = code_a_q;
    rej_b_d  = rej_a_q;
    for (int j = 0; j < 2; j++) begin
      if (!rej_b_d) begin
        if (sd_a_q[j].pz) begin
          rej_b_d = sd_a_q[j].qneg;
        end else if (sd_a_q[j].pneg) begin
          if (t_a_q[j] > tin_b_d) begin
            tin_b_d  = t_a_q[j];
            code_b_d = SIDE_CODE[j+2];
          end
        end else if (t_a_q[j] < tout_b_d) begin
          tout_b_d = t_a_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= vt_q;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tin_a_q  <= tin_a_d;
      tout_a_q <= tout_a_d;
      code_a_q <= code_a_d;
      rej_a_q  <= rej_a_d;
      t_a_q[0] <= t_q[2];
      t_a_q[1] <= t_q[3];
      sd_a_q[0] <= sdt_q[2];
      sd_a_q[1] <= sdt_q[3];
      tin_b_q  <= tin_b_d;
      tout_b_q <= tout_b_d;
      code_b_q <= code_b_d;
      rej_b_q  <= rej_b_d;
    end
  end

  // ---------------- output register: hit test and clamping
  logic         hit_w;
  logic [F:0]   t_enter_w, t_exit_w;
  logic         m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  always_comb begin
    hit_w = !rej_b_q && (tin_b_q <= tout_b_q) && (tin_b_q >= 0) && (tin_b_q <= T_ONE);
    if (tin_b_q < 0) begin
      t_enter_w = '0;
    end else if (tin_b_q > T_ONE) begin
      t_enter_w = T_ONE[F:0];
    end else begin
      t_enter_w = tin_b_q[F:0];
    end
    if (tout_b_q < 0) begin
      t_exit_w = '0;
    end else if (tout_b_q > T_ONE) begin
      t_exit_w = T_ONE[F:0];
    end else begin
      t_exit_w = tout_b_q[F:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= OUT_W'({code_b_q, t_exit_w, t_enter_w, hit_w});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== hw/rtl/sbct_checker.sv =====
// Port-level checker for segment_box_clip_test, attached by bind.
// Depends on segment_box_clip_test_macros.svh and sbct_pkg.
`include "segment_box_clip_test_macros.svh"

module sbct_checker #(
  parameter int unsigned T_FRAC_BITS = sbct_pkg::T_FRAC_BITS_DEF
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((2*T_FRAC_BITS+6+7)/8)*8-1:0] m_axis_tdata
);
  import sbct_pkg::*;

  localparam int unsigned F = T_FRAC_BITS;

  logic [F:0] t_enter, t_exit;
  logic       hit;
  logic [F:0] t_one;

  assign hit     = m_axis_tdata[0];
  assign t_enter = m_axis_tdata[F+1:1];
  assign t_exit  = m_axis_tdata[2*F+2:F+2];
  assign t_one   = {1'b1, {F{1'b0}}};

  `SBCT_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `SBCT_ASSERT_IMP(a_ready, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
  `SBCT_ASSERT_IMP(a_order, clk_i, rst_ni, m_axis_tvalid && hit, t_enter <= t_exit, "hit with entry after exit")
  `SBCT_ASSERT_IMP(a_range, clk_i, rst_ni, m_axis_tvalid, (t_enter <= t_one) && (t_exit <= t_one), "parameter out of range")

endmodule

bind segment_box_clip_test sbct_checker #(.T_FRAC_BITS(T_FRAC_BITS)) u_sbct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/segment_box_clip_test_tb.sv =====
// Self-checking testbench for segment_box_clip_test: segment/box clip requests with random stalls.
// Depends on sbct_pkg and the segment_box_clip_test RTL.
module segment_box_clip_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbct_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int TF = T_FRAC_BITS_DEF;
  localparam int IN_W = ((8*CW+7)/8)*8;
  localparam int OUT_W = ((2*TF+6+7)/8)*8;
  localparam longint T_ONE = longint'(1) << TF;
  localparam int LATENCY = 5 + (CW+1+TF+3)/4;

  // Packed from the top bit down, so hit lands in bit 0 as on the port.
  typedef struct packed {
    logic [2:0]       normal_code;
    logic [TF:0]      t_exit;
    logic [TF:0]      t_enter;
    logic             hit;
  } clip_result_t;

  typedef struct {
    logic signed [CW-1:0] f [8];
  } clip_request_t;

  int errors = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  class clip_scoreboard;
    clip_result_t pending[$];

    function automatic logic [TF:0] clamp_t(longint t);
      if (t < 0) return '0;
      if (t > T_ONE) return T_ONE[TF:0];
      return t[TF:0];
    endfunction

    // Walks the four sides in order; clears hit when a parallel side lies outside.
    function automatic clip_result_t clip(clip_request_t r);
      longint p[4], q[4], t_in, t_out, t;
      longint dx, dy;
      logic [2:0] code;
      bit ok;
      clip_result_t res;
      dx = longint'(r.f[6]) - longint'(r.f[4]);
      dy = longint'(r.f[7]) - longint'(r.f[5]);
      p = '{-dx, dx, -dy, dy};
      q = '{longint'(r.f[4]) - r.f[0], longint'(r.f[2]) - r.f[4],
            longint'(r.f[5]) - r.f[1], longint'(r.f[3]) - r.f[5]};
      t_in = 0; t_out = T_ONE; code = NORMAL_NONE; ok = 1;
      for (int i = 0; i < 4 && ok; i++) begin
        if (p[i] == 0) begin
          ok = (q[i] >= 0);
        end else begin
          t = (q[i] * T_ONE) / p[i];
          if (p[i] < 0) begin
            if (t > t_in) begin
              t_in = t;
              code = SIDE_CODE[i];
            end
          end else if (t < t_out) begin
            t_out = t;
          end
        end
      end
      res.hit = ok && t_in <= t_out && t_in >= 0 && t_in <= T_ONE;
      res.t_enter = clamp_t(t_in);
      res.t_exit = clamp_t(t_out);
      res.normal_code = code;
      return res;
    endfunction

    function void note_request(clip_request_t r);
      pending = {pending, clip(r)};
    endfunction

    task check_result(clip_result_t got);
      clip_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", longint'(got), 0);
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit)
        report_mismatch("hit", longint'(got.hit), longint'(want.hit));
      if (got.t_enter !== want.t_enter)
        report_mismatch("t_enter", longint'(got.t_enter), longint'(want.t_enter));
      if (got.t_exit !== want.t_exit)
        report_mismatch("t_exit", longint'(got.t_exit), longint'(want.t_exit));
      if (got.normal_code !== want.normal_code)
        report_mismatch("normal_code", longint'(got.normal_code), longint'(want.normal_code));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;

  clip_scoreboard board = new();
  bit hold_off = 0;
  bit stim_done = 0;

  always #2 clk_i = ~clk_i;

  segment_box_clip_test u_top (.*);

  function automatic logic [IN_W-1:0] pack_request(clip_request_t r);
    logic [IN_W-1:0] d = '0;
    for (int i = 0; i < 8; i++) d[i*CW +: CW] = r.f[i];
    return d;
  endfunction

  // Called at a falling edge; tvalid stays high after a request unless a gap follows.
  task automatic send_request(clip_request_t r);
    int gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= pack_request(r);
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int kind);
    case (kind)
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 256))) - 16'sd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly boxes with segments near them so that all side outcomes occur.
  function automatic clip_request_t random_request();
    clip_request_t r;
    int kind = $urandom_range(0, 9);
    logic signed [CW-1:0] a, b;
    if (kind < 6) begin
      a = rand_coord(1); b = rand_coord(1);
      r.f[0] = a < b ? a : b; r.f[2] = a < b ? b : a;
      a = rand_coord(1); b = rand_coord(1);
      r.f[1] = a < b ? a : b; r.f[3] = a < b ? b : a;
      for (int i = 4; i < 8; i++) r.f[i] = CW'(rand_coord(1) * 2);
      if ($urandom_range(0, 4) == 0) r.f[6] = r.f[4];
      if ($urandom_range(0, 4) == 0) r.f[7] = r.f[5];
    end else begin
      for (int i = 0; i < 8; i++) r.f[i] = rand_coord(kind == 9 ? 0 : 2);
    end
    return r;
  endfunction

  initial begin
    clip_request_t r;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // Directed: crossing each side, parallel reject, degenerate points, extremes.
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, -16'sd200, 16'sd0, 16'sd200, 16'sd0};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, 16'sd200, 16'sd0, -16'sd200, 16'sd0};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, 16'sd0, -16'sd200, 16'sd0, 16'sd200};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, 16'sd0, 16'sd200, 16'sd0, -16'sd200};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, -16'sd200, -16'sd200, 16'sd200, -16'sd200};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, 16'sd200, 16'sd0, 16'sd200, 16'sd50};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, 16'sd100, 16'sd100, 16'sd100, 16'sd100};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, -16'sd10, 16'sd0, 16'sd10, 16'sd0};
    send_request(r);
    r.f = '{-16'sd64, -16'sd64, 16'sd64, 16'sd64, -16'sd300, -16'sd300, -16'sd100, -16'sd100};
    send_request(r);
    r.f = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
            16'sh7FFF, 16'sh7FFF};
    send_request(r);
    r.f = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000,
            16'sh8000, 16'sh7FFF};
    send_request(r);
    r.f = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
    send_request(r);
    r.f = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh8000};
    send_request(r);
    r.f = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'sh7FFF, 16'sh7FFF};
    send_request(r);
    r.f = '{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1};
    send_request(r);
    for (int n = 0; n < 1000; n++) begin
      if (n == 400) hold_off = 1;
      if (n >= 400 && n < 460) begin
        // Back-to-back requests while the receiver holds off.
        r = random_request();
        s_axis_tvalid <= 1;
        s_axis_tdata <= pack_request(r);
        do @(posedge clk_i); while (!s_axis_tready);
        board.note_request(r);
        @(negedge clk_i);
      end else begin
        send_request(random_request());
      end
    end
    s_axis_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    int gap;
    bit held;
    held = 0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off && !held) begin
        held = 1;
        m_axis_tready <= 0;
        repeat (200) @(negedge clk_i);
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(clip_result_t'(m_axis_tdata[$bits(clip_result_t)-1:0]));
      @(negedge clk_i);
    end
  end

  initial begin
    wait (stim_done);
    wait (board.pending.size() == 0);
    repeat (4 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end
endmodule
